// File: rtl/core/maa_pkg.sv
// Shared constants and types for the multi-axis moving average core.
`timescale 1ns / 1ps

package maa_pkg;

    localparam int RING_DEPTH   = 32;
    localparam int AXES         = 3;

    localparam int AXIS_W       = 2;
    localparam int DATA_W       = 32;
    localparam int WIN_W        = 6;
    localparam int NUM_WIN_REGS = 3;
    localparam int CFG_IDX_W    = 2;

    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int CNT_W        = $clog2(RING_DEPTH + 1);
    localparam int SUM_W        = DATA_W + PTR_W + 1;
    localparam int ENTRIES      = AXES * RING_DEPTH;
    localparam int ADDR_W       = $clog2(ENTRIES);
    localparam int AX_W         = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int DIV_STEP_W   = $clog2(SUM_W);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_AXIS0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_AXIS1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_AXIS2 = CFG_IDX_W'(2);

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              clr_en;
        logic [AX_W-1:0]   clr_axis;
    } t_ring_req;

endpackage

// File: rtl/core/maa_in_if.sv
// Input channel: axis number and sample word.
`timescale 1ns / 1ps

interface maa_in_if;
    logic                              valid;
    logic                              ready;
    logic [maa_pkg::AXIS_W-1:0]        axis_sel;
    logic signed [maa_pkg::DATA_W-1:0] sample_in;

    modport source (output valid, output axis_sel, output sample_in, input ready);
    modport sink   (input valid, input axis_sel, input sample_in, output ready);
endinterface

// File: rtl/core/maa_out_if.sv
// Output channel: axis number and averaged word.
`timescale 1ns / 1ps

interface maa_out_if;
    logic                              valid;
    logic                              ready;
    logic [maa_pkg::AXIS_W-1:0]        axis_out;
    logic signed [maa_pkg::DATA_W-1:0] average_out;

    modport source (output valid, output axis_out, output average_out, input ready);
    modport sink   (input valid, input axis_out, input average_out, output ready);
endinterface

// File: rtl/core/maa_divider.sv
// Serial signed divider: one quotient bit per cycle, truncation toward zero.
`timescale 1ns / 1ps

module maa_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  maa_pkg::t_div_req                 i_req,
    output logic                              o_busy,
    output logic                              o_done,
    output logic signed [maa_pkg::DATA_W-1:0] o_quot
);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} t_dstate;

    t_dstate                        r_state;
    logic [maa_pkg::CNT_W-1:0]      r_rem;
    logic [maa_pkg::SUM_W-1:0]      r_quo;
    logic [maa_pkg::CNT_W-1:0]      r_dvs;
    logic                           r_neg;
    logic [maa_pkg::DIV_STEP_W-1:0] r_step;
    logic                           r_done;
    logic signed [maa_pkg::DATA_W-1:0] r_quot;

    logic [maa_pkg::CNT_W:0]   n_rem_sh;
    logic [maa_pkg::CNT_W:0]   n_rem_sub;
    logic [maa_pkg::SUM_W-1:0] n_quo;
    logic [maa_pkg::CNT_W-1:0] n_rem;
    logic [maa_pkg::SUM_W-1:0] n_mag;

    always_comb begin
        n_rem_sh  = {r_rem, r_quo[maa_pkg::SUM_W-1]};
        n_rem_sub = n_rem_sh - {1'b0, r_dvs};
        n_quo     = {r_quo[maa_pkg::SUM_W-2:0], 1'b0};
        n_rem     = n_rem_sh[maa_pkg::CNT_W-1:0];
        if (n_rem_sh >= {1'b0, r_dvs}) begin
            n_rem    = n_rem_sub[maa_pkg::CNT_W-1:0];
            n_quo[0] = 1'b1;
        end
        n_mag = i_req.dividend[maa_pkg::SUM_W-1] ? (~i_req.dividend + 1'b1)
                                                  : i_req.dividend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_rem   <= '0;
                        r_quo   <= n_mag;
                        r_dvs   <= i_req.divisor;
                        r_neg   <= i_req.dividend[maa_pkg::SUM_W-1];
                        r_step  <= maa_pkg::DIV_STEP_W'(maa_pkg::SUM_W - 1);
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= D_FIX;
                    end
                end
                D_FIX: begin
                    r_quot  <= maa_pkg::DATA_W'(r_neg ? (~r_quo + 1'b1) : r_quo);
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != D_IDLE);
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/core/maa_ring.sv
// Sample ring memory for all axes, with per-entry valid bits for clearing.
`timescale 1ns / 1ps

module maa_ring (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  maa_pkg::t_ring_req         i_req,
    output logic [maa_pkg::DATA_W-1:0] o_rdata
);

    logic [maa_pkg::DATA_W-1:0] r_mem [maa_pkg::ENTRIES];
    logic [maa_pkg::ENTRIES-1:0] r_valid;
    logic [maa_pkg::DATA_W-1:0] r_rdata;
    logic                       r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    // entries never written since reset or a window change read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rvalid <= r_valid[i_req.rd_addr];
            end
            if (i_req.clr_en) begin
                for (int a = 0; a < maa_pkg::AXES; a++) begin
                    for (int k = 0; k < maa_pkg::RING_DEPTH; k++) begin
                        if (i_req.clr_axis == maa_pkg::AX_W'(a)) begin
                            r_valid[a * maa_pkg::RING_DEPTH + k] <= 1'b0;
                        end
                    end
                end
            end
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// File: rtl/core/multi_axis_moving_average_core.sv
// Top level: per-axis boxcar moving average with a shared serial divider.
//
//  channel   dir  handshake         payload
//  i_samp    in   valid/ready       axis_sel[1:0], sample_in[31:0] signed
//  o_avg     out  valid/ready       axis_out[1:0], average_out[31:0] signed
//  i_cfg_*   in   write enable only i_cfg_idx[1:0], i_cfg_data[5:0]
//
// An averaging word passes from accept through the load state, the serial
// divider and the finish state into the result register; a pass-through
// word skips the divider. One word is in work at a time; the next is taken
// while the result register still waits. Reset is synchronous and clears
// windows, sums, pointers and ring valid bits. A stalled result holds the
// core in its finish state until taken.
`timescale 1ns / 1ps

module multi_axis_moving_average_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    maa_in_if.sink                        i_samp,
    maa_out_if.source                     o_avg,
    input  logic                          i_cfg_we,
    input  logic [maa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [maa_pkg::WIN_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_DONE} t_state;

    t_state                              r_state;
    logic [maa_pkg::AXIS_W-1:0]          r_axis;
    logic signed [maa_pkg::DATA_W-1:0]   r_sample;
    logic signed [maa_pkg::DATA_W-1:0]   r_result;
    logic                                r_out_valid;
    logic [maa_pkg::AXIS_W-1:0]          r_out_axis;
    logic signed [maa_pkg::DATA_W-1:0]   r_out_data;
    logic [maa_pkg::WIN_W-1:0]           r_window [maa_pkg::AXES];
    logic signed [maa_pkg::SUM_W-1:0]    r_sum    [maa_pkg::AXES];
    logic [maa_pkg::PTR_W-1:0]           r_ptr    [maa_pkg::AXES];

    maa_pkg::t_div_req                   div_req;
    maa_pkg::t_ring_req                  ring_req;
    logic                                div_busy;
    logic                                div_done;
    logic signed [maa_pkg::DATA_W-1:0]   div_quot;
    logic [maa_pkg::DATA_W-1:0]          ring_rdata;

    logic [maa_pkg::AX_W-1:0]            ax;
    logic                                ax_ok;
    logic [maa_pkg::CNT_W-1:0]           win_eff;
    logic                                do_avg;
    logic [maa_pkg::PTR_W-1:0]           p_cur;
    logic [maa_pkg::CNT_W-1:0]           p_inc;
    logic [maa_pkg::PTR_W-1:0]           p_next;
    logic signed [maa_pkg::SUM_W-1:0]    sum_add;
    logic signed [maa_pkg::SUM_W-1:0]    old_ext;
    logic                                cfg_hit;
    logic [maa_pkg::AX_W-1:0]            cfg_ax;
    logic                                out_free;

    function automatic logic [maa_pkg::ADDR_W-1:0] ring_addr(
        input logic [maa_pkg::AX_W-1:0]  a,
        input logic [maa_pkg::PTR_W-1:0] p
    );
        return maa_pkg::ADDR_W'(int'(a) * maa_pkg::RING_DEPTH) + maa_pkg::ADDR_W'(p);
    endfunction

    always_comb begin
        ax    = maa_pkg::AX_W'(r_axis);
        ax_ok = (int'(r_axis) < maa_pkg::AXES);
        if (int'(r_window[ax]) > maa_pkg::RING_DEPTH) begin
            win_eff = maa_pkg::CNT_W'(maa_pkg::RING_DEPTH);
        end else begin
            win_eff = maa_pkg::CNT_W'(r_window[ax]);
        end
        do_avg = ax_ok && (win_eff > maa_pkg::CNT_W'(1));

        p_cur = r_ptr[ax];
        if (maa_pkg::CNT_W'(p_cur) >= win_eff) begin
            p_cur = '0;
        end
        p_inc  = maa_pkg::CNT_W'(p_cur) + 1'b1;
        p_next = (p_inc >= win_eff) ? '0 : maa_pkg::PTR_W'(p_inc);

        sum_add = r_sum[ax] + {{(maa_pkg::SUM_W - maa_pkg::DATA_W){r_sample[maa_pkg::DATA_W-1]}},
                               r_sample};
        old_ext = {{(maa_pkg::SUM_W - maa_pkg::DATA_W){ring_rdata[maa_pkg::DATA_W-1]}},
                   ring_rdata};

        case (i_cfg_idx)
            maa_pkg::REG_WINDOW_AXIS0,
            maa_pkg::REG_WINDOW_AXIS1,
            maa_pkg::REG_WINDOW_AXIS2: cfg_hit = i_cfg_we && (int'(i_cfg_idx) < maa_pkg::AXES);
            default:                   cfg_hit = 1'b0;
        endcase
        cfg_ax = maa_pkg::AX_W'(i_cfg_idx);

        out_free = !r_out_valid || o_avg.ready;

        div_req.start    = (r_state == S_LOAD) && do_avg;
        div_req.dividend = sum_add;
        div_req.divisor  = win_eff;

        ring_req.wr_en    = (r_state == S_LOAD) && do_avg;
        ring_req.wr_addr  = ring_addr(ax, p_cur);
        ring_req.wr_data  = r_sample;
        ring_req.rd_en    = (r_state == S_LOAD) && do_avg;
        ring_req.rd_addr  = ring_addr(ax, p_next);
        ring_req.clr_en   = cfg_hit;
        ring_req.clr_axis = cfg_ax;
    end

    maa_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    maa_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ring_req),
        .o_rdata (ring_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int a = 0; a < maa_pkg::AXES; a++) begin
                r_window[a] <= '0;
                r_sum[a]    <= '0;
                r_ptr[a]    <= '0;
            end
        end else begin
            if (r_out_valid && o_avg.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_hit) begin
                r_window[cfg_ax] <= i_cfg_data;
                r_sum[cfg_ax]    <= '0;
                r_ptr[cfg_ax]    <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_samp.valid) begin
                        r_axis   <= i_samp.axis_sel;
                        r_sample <= i_samp.sample_in;
                        r_state  <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_result <= r_sample;
                    if (do_avg) begin
                        r_sum[ax] <= sum_add;
                        r_ptr[ax] <= p_next;
                        r_state   <= S_DIV;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    // drop the oldest word once the quotient is out
                    if (div_done) begin
                        r_result  <= div_quot;
                        r_sum[ax] <= r_sum[ax] - old_ext;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_axis  <= r_axis;
                        r_out_data  <= r_result;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_samp.ready      = (r_state == S_IDLE);
    assign o_avg.valid       = r_out_valid;
    assign o_avg.axis_out    = r_out_axis;
    assign o_avg.average_out = r_out_data;

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_samp.valid && i_samp.ready) |=> (r_state == S_LOAD))
        else $error("accepted word did not enter load");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_div_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && do_avg) |=> (div_busy && r_state == S_DIV))
        else $error("divider not running after load");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result word not registered");

endmodule

// File: test/maa_average_monitor.sv
// Channel monitor for the moving average core: predicts every averaged word and compares.
`timescale 1ns / 1ps

module maa_average_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    maa_in_if                             i_samp,
    maa_out_if                            i_avg,
    input  logic                          i_cfg_we,
    input  logic [maa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [maa_pkg::WIN_W-1:0]     i_cfg_data,
    output int                            o_mismatches,
    output int                            o_pending
);
    import maa_pkg::*;

    localparam int PRINT_LIMIT = 50;

    typedef struct {
        logic [AXIS_W-1:0]        axis;
        logic signed [DATA_W-1:0] average;
    } avg_word_t;

    avg_word_t                expected_avg_q[$];
    logic signed [DATA_W-1:0] ring_q [AXES][RING_DEPTH];
    longint                   run_sum [AXES];
    int unsigned              wr_ptr [AXES];
    logic [WIN_W-1:0]         win_reg [AXES];

    initial o_mismatches = 0;

    task automatic report_mismatch(input string msg);
        if (o_mismatches < PRINT_LIMIT) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
        o_mismatches++;
    endtask

    task automatic clear_axis(input int a);
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_q[a][i] = '0;
        end
        run_sum[a] = 0;
        wr_ptr[a]  = 0;
    endtask

    // One word through the boxcar of its axis; state moves on, average comes back.
    task automatic advance_window(input logic [AXIS_W-1:0] ax,
                                  input logic signed [DATA_W-1:0] smp,
                                  output logic signed [DATA_W-1:0] avg);
        int unsigned win;
        int unsigned ptr;
        longint      quot;
        avg = smp;
        if (ax < AXES) begin
            // register values past the ring depth saturate
            win = (win_reg[ax] > RING_DEPTH) ? RING_DEPTH : win_reg[ax];
            if (win > 1) begin
                ptr = (wr_ptr[ax] >= win) ? 0 : wr_ptr[ax];
                ring_q[ax][ptr] = smp;
                run_sum[ax] += longint'(smp);
                ptr = (ptr + 1 >= win) ? 0 : ptr + 1;
                wr_ptr[ax] = ptr;
                // SV division truncates toward zero
                quot = run_sum[ax] / longint'(win);
                avg = quot[DATA_W-1:0];
                run_sum[ax] -= longint'(ring_q[ax][ptr]);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        avg_word_t                want;
        avg_word_t                next_word;
        logic signed [DATA_W-1:0] predicted;
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                win_reg[a] = '0;
                clear_axis(a);
            end
            expected_avg_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we && i_cfg_idx < NUM_WIN_REGS && i_cfg_idx < AXES) begin
                win_reg[i_cfg_idx] = i_cfg_data;
                clear_axis(i_cfg_idx);
            end
            // result side first: a word taken at this edge belongs to an older sample
            if (i_avg.valid && i_avg.ready) begin
                if (expected_avg_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word, axis %0d average %h",
                                              i_avg.axis_out, i_avg.average_out));
                end else begin
                    want = expected_avg_q.pop_front();
                    if (i_avg.axis_out !== want.axis) begin
                        report_mismatch($sformatf("axis_out %0d, expected %0d",
                                                  i_avg.axis_out, want.axis));
                    end
                    if (i_avg.average_out !== want.average) begin
                        report_mismatch($sformatf("axis %0d average_out %h, expected %h",
                                                  want.axis, i_avg.average_out,
                                                  want.average));
                    end
                end
            end
            if (i_samp.valid && i_samp.ready) begin
                advance_window(i_samp.axis_sel, i_samp.sample_in, predicted);
                next_word.axis    = i_samp.axis_sel;
                next_word.average = predicted;
                expected_avg_q.push_back(next_word);
            end
            o_pending <= expected_avg_q.size();
        end
    end

endmodule

// File: test/tb_multi_axis_moving_average_core.sv
// Testbench top for the multi-axis moving average core: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_multi_axis_moving_average_core;
    import maa_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 50;
    localparam int TOTAL_WORDS   = 1550;

    localparam logic [CFG_IDX_W-1:0]    REG_UNMAPPED  = CFG_IDX_W'(3);
    localparam logic [AXIS_W-1:0]       AXIS_UNMAPPED = AXIS_W'(3);
    localparam logic signed [DATA_W-1:0] SAMPLE_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAMPLE_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [WIN_W-1:0]     i_cfg_data;

    bit no_idle;
    int mismatches;
    int pending;
    int words_sent;
    int idle_cycles;

    maa_in_if  samp_if ();
    maa_out_if avg_if ();

    multi_axis_moving_average_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_samp     (samp_if),
        .o_avg      (avg_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    maa_average_monitor average_mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_samp       (samp_if),
        .i_avg        (avg_if),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_word(input logic [AXIS_W-1:0] ax,
                             input logic signed [DATA_W-1:0] smp);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            samp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        samp_if.valid     <= 1'b1;
        samp_if.axis_sel  <= ax;
        samp_if.sample_in <= smp;
        do @(posedge i_clk); while (!samp_if.ready);
        words_sent++;
    endtask

    // pending is a registered copy of the queue size, so look only from the edge after the last accept
    task automatic wait_drained();
        samp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // result side: random stall before each word
    initial begin
        int unsigned stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                avg_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            avg_if.ready <= 1'b1;
            do @(posedge i_clk); while (!avg_if.valid);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((samp_if.valid && samp_if.ready) || (avg_if.valid && avg_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[multi_axis_moving_average_core] ERROR");
        $finish;
    end

    initial begin
        logic [WIN_W-1:0]         pick;
        logic [AXIS_W-1:0]        ax;
        logic signed [DATA_W-1:0] smp;
        logic signed [DATA_W-1:0] bias;
        int unsigned              span;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        samp_if.valid     <= 1'b0;
        samp_if.axis_sel  <= '0;
        samp_if.sample_in <= '0;
        no_idle    = 1'b0;
        words_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all windows at zero after reset: everything passes through
        send_word(AXIS_W'(0), SAMPLE_MIN);
        send_word(AXIS_W'(1), SAMPLE_MAX);
        send_word(AXIS_W'(2), '0);
        send_word(AXIS_UNMAPPED, -1);
        wait_drained();

        write_window(REG_WINDOW_AXIS0, WIN_W'(2));
        write_window(REG_WINDOW_AXIS1, WIN_W'(63));   // saturates to ring depth
        write_window(REG_WINDOW_AXIS2, WIN_W'(1));
        write_window(REG_UNMAPPED, WIN_W'(5));        // no such register

        send_word(AXIS_W'(0), -1);                    // -1/2 truncates to zero
        send_word(AXIS_W'(0), '0);
        send_word(AXIS_W'(0), SAMPLE_MIN);
        send_word(AXIS_W'(0), SAMPLE_MIN);
        send_word(AXIS_W'(0), SAMPLE_MAX);
        send_word(AXIS_W'(0), SAMPLE_MAX);
        send_word(AXIS_W'(1), SAMPLE_MIN);
        send_word(AXIS_W'(1), SAMPLE_MIN);
        send_word(AXIS_W'(1), SAMPLE_MIN);
        send_word(AXIS_W'(1), SAMPLE_MAX);
        send_word(AXIS_W'(2), -5);
        send_word(AXIS_UNMAPPED, 12345);
        send_word(AXIS_W'(0), 3);

        while (words_sent < TOTAL_WORDS) begin
            wait_drained();
            for (int r = 0; r <= int'(REG_UNMAPPED); r++) begin
                // skipping a write keeps that axis's history across the phase
                if ($urandom_range(0, 2) != 0) begin
                    case ($urandom_range(0, 7))
                        0:       pick = WIN_W'(0);
                        1:       pick = WIN_W'(1);
                        2:       pick = WIN_W'(2);
                        3:       pick = WIN_W'(RING_DEPTH);
                        4:       pick = '1;
                        5:       pick = WIN_W'(RING_DEPTH + 1);
                        default: pick = WIN_W'($urandom_range(0, 63));
                    endcase
                    write_window(CFG_IDX_W'(r), pick);
                end
            end
            no_idle = ($urandom_range(0, 3) == 0);
            span    = $urandom_range(30, 120);
            case ($urandom_range(0, 2))
                0:       bias = SAMPLE_MAX;
                1:       bias = SAMPLE_MIN;
                default: bias = $urandom;
            endcase
            for (int k = 0; k < span && words_sent < TOTAL_WORDS; k++) begin
                if (k == span / 2 && $urandom_range(0, 2) == 0) begin
                    wait_drained();
                end
                ax = ($urandom_range(0, 15) == 0) ? AXIS_UNMAPPED
                                                  : AXIS_W'($urandom_range(0, AXES - 1));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: smp = $urandom;
                    4, 5, 6:    smp = int'($urandom_range(0, 2000)) - 1000;
                    7: begin
                        case ($urandom_range(0, 4))
                            0:       smp = SAMPLE_MAX;
                            1:       smp = SAMPLE_MIN;
                            2:       smp = -1;
                            3:       smp = 1;
                            default: smp = '0;
                        endcase
                    end
                    // long runs of one value drive the sums to their extremes
                    default:    smp = bias;
                endcase
                send_word(ax, smp);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("[multi_axis_moving_average_core] OK");
        end else begin
            $display("[multi_axis_moving_average_core] ERROR");
        end
        $finish;
    end

endmodule
